FILE: hw/rtl/wns_pkg.sv
// Shared constants, codes and controller/datapath interface types for the node sampler.
package wns_pkg;

  // Table geometry.
  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;

  // Field and arithmetic widths.
  localparam int WEIGHT_W = 32;
  localparam int FRAC_W   = 32;
  localparam int TOTAL_W  = 48;
  localparam int THI_W    = TOTAL_W - 32;
  localparam int PLO_W    = FRAC_W + 32;
  localparam int PHI_W    = FRAC_W + THI_W;
  localparam int Q_W      = PHI_W + 1;
  localparam int SUM_W    = WEIGHT_W + CNT_W;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_ORDER  = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             wr_weight;
    logic             wr_order;
    logic             mul;
    logic             qsum;
    logic             acc;
    logic [CNT_W-1:0] pos;
  } wns_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             positive;
    logic [CNT_W-1:0] count;
  } wns_stat_t;

endpackage

FILE: hw/rtl/weighted_node_sampler_unit.sv
// Top level of the weighted node sampler: controller plus datapath.
//
// Items are presented on start with kind and the payload fields; an item is
// taken at a clock edge where start is high and busy is low. Kind 0 stores
// weight_value at index, kind 1 stores order_value in the seed order at index;
// both keep busy high in the write state and give no result. Kind 3 is dropped.
// Kind 2 scales uniform_fraction by total_weight and walks the nodes, taking
// weights one per cycle until the remainder is no longer positive or the nodes
// run out; its result shows on chosen_node and numeric_error with done high for
// one cycle. The receiver cannot stall, so each result is a transfer in its done
// cycle. A sample steps through the split product, the aligned sum of the
// partial products, the scan loop with one position issued per cycle, the
// drain of the memory read pipeline, the end of the scan and the done cycle.
// busy drops the cycle after done. Sampling is one item at a time. seed_count
// is written on the cfg channel (cfg_ready is always high); the user must write
// it only while busy is low, and the block itself does not enforce this.
// Synchronous reset clears the controller, the remainder flag and seed_count;
// the tables keep no reset value and must be written before use.
module weighted_node_sampler_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind,
  input  logic [wns_pkg::IDX_W-1:0]    index,
  input  logic [wns_pkg::WEIGHT_W-1:0] weight_value,
  input  logic [wns_pkg::IDX_W-1:0]    order_value,
  input  logic [wns_pkg::CNT_W-1:0]    node_count,
  input  logic [wns_pkg::TOTAL_W-1:0]  total_weight,
  input  logic [wns_pkg::FRAC_W-1:0]   uniform_fraction,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wns_pkg::CNT_W-1:0]    cfg_data,
  output logic                         done,
  output logic [wns_pkg::IDX_W-1:0]    chosen_node,
  output logic                         numeric_error
);
  import wns_pkg::*;

  wns_cmd_t  cmd;
  wns_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencing.
  wns_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Storage and arithmetic.
  wns_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .index            (index),
    .weight_value     (weight_value),
    .order_value      (order_value),
    .node_count       (node_count),
    .total_weight     (total_weight),
    .uniform_fraction (uniform_fraction),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .chosen_node      (chosen_node),
    .numeric_error    (numeric_error)
  );

endmodule

FILE: hw/rtl/wns_dpath.sv
// Datapath: weight and seed order memories, scaled product and the scan pipeline.
module wns_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  wns_pkg::wns_cmd_t            cmd,
  output wns_pkg::wns_stat_t           stat,
  input  logic [wns_pkg::IDX_W-1:0]    index,
  input  logic [wns_pkg::WEIGHT_W-1:0] weight_value,
  input  logic [wns_pkg::IDX_W-1:0]    order_value,
  input  logic [wns_pkg::CNT_W-1:0]    node_count,
  input  logic [wns_pkg::TOTAL_W-1:0]  total_weight,
  input  logic [wns_pkg::FRAC_W-1:0]   uniform_fraction,
  input  logic                         cfg_valid,
  input  logic [wns_pkg::CNT_W-1:0]    cfg_data,
  output logic [wns_pkg::IDX_W-1:0]    chosen_node,
  output logic                         numeric_error
);
  import wns_pkg::*;

  // Storage.
  logic [WEIGHT_W-1:0] weight_mem [MAX_NODES];
  logic [IDX_W-1:0]    order_mem  [MAX_NODES];

  // Captured operands.
  logic [IDX_W-1:0]    idx_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [IDX_W-1:0]    order_q;
  logic [CNT_W-1:0]    count_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [FRAC_W-1:0]   frac_q;
  logic [CNT_W-1:0]    seed_count;

  // Arithmetic.
  logic [PLO_W-1:0]    p_lo;
  logic [PHI_W-1:0]    p_hi;
  logic [Q_W-1:0]      q;
  logic                rem;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [Q_W-1:0]      sum_ext;
  logic                positive;
  logic                positive_next;
  logic [IDX_W-1:0]    node;

  // Scan pipeline.
  logic [IDX_W-1:0]    seed_rd;
  logic [IDX_W-1:0]    a_pos;
  logic                a_seed;
  logic [IDX_W-1:0]    b_node;
  logic [IDX_W-1:0]    c_node;
  logic [WEIGHT_W-1:0] weight_rd;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_count <= '0;
    end else if (cfg_valid) begin
      seed_count <= cfg_data;
    end
  end

  // Operand capture on an accepted item; the count saturates at the table size.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q    <= index;
      weight_q <= weight_value;
      order_q  <= order_value;
      frac_q   <= uniform_fraction;
      total_q  <= total_weight;
      if (node_count > CNT_W'(MAX_NODES)) begin
        count_q <= CNT_W'(MAX_NODES);
      end else begin
        count_q <= node_count;
      end
    end
  end

  // Table writes from the captured operands.
  always_ff @(posedge clk) begin
    if (cmd.wr_weight) begin
      weight_mem[idx_q] <= weight_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_order) begin
      order_mem[idx_q] <= order_q;
    end
  end

  // Scaled value: two partial products, then their aligned sum.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_lo <= PLO_W'(frac_q) * PLO_W'(total_q[31:0]);
      p_hi <= PHI_W'(frac_q) * PHI_W'(total_q[TOTAL_W-1:32]);
    end
  end

  // Stage A: seed order read at the issued position.
  always_ff @(posedge clk) begin
    seed_rd <= order_mem[cmd.pos[IDX_W-1:0]];
    a_pos   <= cmd.pos[IDX_W-1:0];
    a_seed  <= (cmd.pos < seed_count);
  end

  // Stage B: pick the node and read its weight.
  assign b_node = a_seed ? seed_rd : a_pos;

  always_ff @(posedge clk) begin
    weight_rd <= weight_mem[b_node];
    c_node    <= b_node;
  end

  // Stage C: accumulate and compare against the scaled value.
  assign sum_next      = sum + SUM_W'(weight_rd);
  assign sum_ext       = Q_W'(sum_next);
  assign positive_next = (q > sum_ext) || ((q == sum_ext) && rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      positive <= 1'b0;
    end else if (cmd.qsum) begin
      q        <= Q_W'(p_hi) + Q_W'(p_lo[PLO_W-1:32]);
      rem      <= |p_lo[31:0];
      positive <= (|p_hi) || (|p_lo);
      sum      <= '0;
      node     <= '0;
    end else if (cmd.acc && positive) begin
      sum      <= sum_next;
      node     <= c_node;
      positive <= positive_next;
    end
  end

  // Status and result.
  assign stat.positive = positive;
  assign stat.count    = count_q;
  assign chosen_node   = node;
  assign numeric_error = positive;

endmodule

FILE: hw/rtl/wns_ctrl.sv
// Controller: item sequencing, scan position counter and pipeline valid flags.
module wns_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         kind,
  output logic               busy,
  output logic               done,
  output wns_pkg::wns_cmd_t  cmd,
  input  wns_pkg::wns_stat_t stat
);
  import wns_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_MUL,
    S_SUM,
    S_SCAN,
    S_DONE
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [1:0]       kind_q;
  logic [CNT_W-1:0] pos;
  logic             vb;
  logic             vc;
  logic             accept;
  logic             issue;
  logic             scan_end;

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign accept = start && !busy;

  // A position is issued while the remainder is positive and positions remain.
  assign issue    = (state == S_SCAN) && stat.positive && (pos < stat.count);
  assign scan_end = !stat.positive || ((pos >= stat.count) && !vb && !vc);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (kind == KIND_WEIGHT || kind == KIND_ORDER) begin
            state_next = S_WRITE;
          end else if (kind == KIND_SAMPLE) begin
            state_next = S_MUL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_WRITE: state_next = S_IDLE;
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State, kind latch, position counter and stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind_q <= '0;
      pos    <= '0;
      vb     <= 1'b0;
      vc     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        kind_q <= kind;
      end
      if (state == S_SUM) begin
        pos <= '0;
      end else if (issue) begin
        pos <= pos + CNT_W'(1);
      end
      if (state == S_SCAN && !scan_end) begin
        vb <= issue;
        vc <= vb;
      end else begin
        vb <= 1'b0;
        vc <= 1'b0;
      end
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.wr_weight = (state == S_WRITE) && (kind_q == KIND_WEIGHT);
    cmd.wr_order  = (state == S_WRITE) && (kind_q == KIND_ORDER);
    cmd.mul       = (state == S_MUL);
    cmd.qsum      = (state == S_SUM);
    cmd.acc       = (state == S_SCAN) && vc;
    cmd.pos       = pos;
  end

  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  // The accumulate stage only follows a valid weight read stage.
  a_vc_follows_vb: assert property (@(posedge clk) disable iff (rst) vc |-> $past(vb))
    else $error("accumulate stage valid without a preceding read stage");

  // The scan position never passes the node count.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos <= stat.count))
    else $error("scan position beyond node count");

  // An accepted sample starts the product step.
  a_sample_start: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_SAMPLE) |=> (state == S_MUL))
    else $error("accepted sample did not start the product step");

endmodule
